// ----- rtl/led_matrix_bitplane_scanner_defines.svh -----
// Assertion macros for the LED matrix bit-plane scanner.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef LED_MATRIX_BITPLANE_SCANNER_DEFINES_SVH
`define LED_MATRIX_BITPLANE_SCANNER_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define LMBS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmbs: same-cycle check failed");

// Next-cycle implication, quiet during reset
`define LMBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmbs: next-cycle check failed");

`endif

// ----- rtl/lmbs_pkg.sv -----
// Shared types, codes and helpers for the LED matrix bit-plane scanner.
// No dependencies; used by led_matrix_bitplane_scanner.
`timescale 1ns / 1ps

package lmbs_pkg;

    // Parameter defaults
    localparam int MAX_ROW_PAIRS_DEF = 16;
    localparam int MAX_COLUMNS_DEF   = 128;
    localparam int MAX_DEPTH_DEF     = 8;
    localparam int TIME_BITS_DEF     = 16;

    // Register reset values as seen by software
    localparam int ROW_PAIRS_RST = 16;
    localparam int COLUMNS_RST   = 64;
    localparam int DEPTH_RST     = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PAIRS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 2'd2;

    // Stream widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    // On-time table
    localparam int PLANE_W     = 3;
    localparam int PLANE_COUNT = 8;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_TIME  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        PH_SHIFT  = 2'd0,
        PH_LATCH  = 2'd1,
        PH_ROWEND = 2'd2
    } phase_t;

    // Side information of one tick, carried next to the frame store read
    typedef struct packed {
        logic [3:0]         row_address;
        logic [PLANE_W-1:0] bit_sel;
        logic               strobe;
        logic               latch;
        logic               disp;
    } tick_info_t;

    // Saturate a register value into 1..hi
    function automatic int clamp_cfg(input int v, input int hi);
        int r;
        r = v;
        if (v < 1) begin
            r = 1;
        end
        else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ----- rtl/led_matrix_bitplane_scanner.sv -----
// LED matrix bit-plane scanner: drives a twin-row RGB panel with binary-weighted
// bit planes. Pixel and on-time commands fill the frame store and on-time table;
// each tick command returns one set of panel pin levels on the master stream.
// The block takes one command per clock while the receiver keeps up; with the
// output held, input stalls once the read stage and the output register are both
// full. At the accepting edge of a tick the frame store read register captures
// the upper and lower pixel (two read ports), and the output register loads the
// pin levels from the read stage once the output register is free.
// Pixel and on-time writes give no result. Depends on lmbs_pkg and the defines
// header.
`timescale 1ns / 1ps
`include "led_matrix_bitplane_scanner_defines.svh"

module led_matrix_bitplane_scanner #(
    parameter int MAX_ROW_PAIRS = lmbs_pkg::MAX_ROW_PAIRS_DEF,
    parameter int MAX_COLUMNS   = lmbs_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_DEPTH     = lmbs_pkg::MAX_DEPTH_DEF,
    parameter int TIME_BITS     = lmbs_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Command stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [6:0] pixel_column, [11:7] pixel_row, [19:12] red_level, [27:20] green_level,
    // [35:28] blue_level, [38:36] plane_index, [54:39] plane_on_time, [55] zero
    input  logic [lmbs_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] command
    input  logic [lmbs_pkg::IN_USER_W-1:0]   s_tuser,
    // Pin level stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] row_address, [4] upper_red, [5] upper_green, [6] upper_blue,
    // [7] lower_red, [8] lower_green, [9] lower_blue, [10] shift_strobe,
    // [11] latch_pulse, [12] display_on, [15:13] zero
    output logic [lmbs_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration writes
    input  logic                             cfg_we,
    input  logic [lmbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ROW_W       = (MAX_ROW_PAIRS > 1) ? $clog2(MAX_ROW_PAIRS) : 1;
    localparam int ROWS_W      = $clog2(MAX_ROW_PAIRS + 1);
    localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);
    localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
    localparam int STORE_DEPTH = 2 * MAX_ROW_PAIRS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PL_W        = lmbs_pkg::PLANE_W;

    // Clamped configuration
    logic [ROWS_W-1:0]  rows_reg;
    logic [COLS_W-1:0]  cols_reg;
    logic [DEPTH_W-1:0] depth_reg;

    // Scan state
    lmbs_pkg::phase_t   phase_reg, phase_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [PL_W-1:0]    plane_reg, plane_next;
    logic [TIME_BITS-1:0] ontime_reg, ontime_next;
    logic [TIME_BITS-1:0] time_tbl_reg [lmbs_pkg::PLANE_COUNT];

    // Frame store, red in the top byte
    logic [23:0]        frame_mem [STORE_DEPTH];
    logic [23:0]        up_reg, lo_reg;

    // Pipeline
    logic                     s1_valid_reg, s1_valid_next;
    lmbs_pkg::tick_info_t     s1_info_reg, tick_info;
    logic                     out_valid_reg, out_valid_next;
    logic [lmbs_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Unpacked command fields
    lmbs_pkg::cmd_t     in_cmd;
    logic [6:0]         in_col;
    logic [4:0]         in_row;
    logic [23:0]        in_pixel;
    logic [PL_W-1:0]    in_plane;
    logic [15:0]        in_time;

    logic               accept, tick_acc, pix_acc, time_acc, pix_in_range;
    logic               out_free, s1_go, disp;
    logic [ADDR_W-1:0]  wr_addr, rd_up_addr, rd_lo_addr;
    logic [ROW_W:0]     row_inc, row_lower;
    logic [COL_W:0]     col_inc;
    logic [PL_W:0]      plane_inc;
    logic [5:0]         color_bits;

    assign in_cmd   = lmbs_pkg::cmd_t'(s_tuser);
    assign in_col   = s_tdata[6:0];
    assign in_row   = s_tdata[11:7];
    assign in_pixel = {s_tdata[19:12], s_tdata[27:20], s_tdata[35:28]};
    assign in_plane = s_tdata[38:36];
    assign in_time  = s_tdata[54:39];

    // Handshake: the read stage moves on when the output register is free
    assign out_free = !out_valid_reg || m_tready;
    assign s1_go    = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign tick_acc = accept && (in_cmd == lmbs_pkg::CMD_TICK);
    assign pix_acc  = accept && (in_cmd == lmbs_pkg::CMD_PIXEL) && pix_in_range;
    assign time_acc = accept && (in_cmd == lmbs_pkg::CMD_TIME);

    // Hold clamped configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= ROWS_W'(lmbs_pkg::clamp_cfg(lmbs_pkg::ROW_PAIRS_RST, MAX_ROW_PAIRS));
            cols_reg  <= COLS_W'(lmbs_pkg::clamp_cfg(lmbs_pkg::COLUMNS_RST, MAX_COLUMNS));
            depth_reg <= DEPTH_W'(lmbs_pkg::clamp_cfg(lmbs_pkg::DEPTH_RST, MAX_DEPTH));
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lmbs_pkg::REG_ROW_PAIRS:
                    rows_reg <= ROWS_W'(lmbs_pkg::clamp_cfg(int'(cfg_data[4:0]),
                                                            MAX_ROW_PAIRS));
                lmbs_pkg::REG_COLUMNS:
                    cols_reg <= COLS_W'(lmbs_pkg::clamp_cfg(int'(cfg_data),
                                                            MAX_COLUMNS));
                lmbs_pkg::REG_DEPTH:
                    depth_reg <= DEPTH_W'(lmbs_pkg::clamp_cfg(int'(cfg_data[3:0]),
                                                              MAX_DEPTH));
                default:
                    ;
            endcase
        end
    end

    // Store plane on-times
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lmbs_pkg::PLANE_COUNT; i++)
            begin
                time_tbl_reg[i] <= '0;
            end
        end
        else if (time_acc)
        begin
            time_tbl_reg[in_plane] <= TIME_BITS'(in_time);
        end
    end

    // Frame store addresses
    assign pix_in_range = (32'(in_row) < 32'(2 * MAX_ROW_PAIRS)) &&
                          (32'(in_col) < 32'(MAX_COLUMNS));
    assign wr_addr      = ADDR_W'(32'(in_row) * 32'(MAX_COLUMNS) + 32'(in_col));
    assign row_lower    = (ROW_W + 1)'(row_reg) + (ROW_W + 1)'(rows_reg);
    assign rd_up_addr   = ADDR_W'(32'(row_reg) * 32'(MAX_COLUMNS) + 32'(col_reg));
    assign rd_lo_addr   = ADDR_W'(32'(row_lower) * 32'(MAX_COLUMNS) + 32'(col_reg));

    // Write pixels, read the upper and lower pixel of each tick
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            frame_mem[wr_addr] <= in_pixel;
        end
        if (tick_acc)
        begin
            up_reg <= frame_mem[rd_up_addr];
            lo_reg <= frame_mem[rd_lo_addr];
        end
    end

    // Advance scan state on each tick
    assign disp      = (ontime_reg != '0);
    assign col_inc   = (COL_W + 1)'(col_reg) + (COL_W + 1)'(1);
    assign row_inc   = (ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1);
    assign plane_inc = (PL_W + 1)'(plane_reg) + (PL_W + 1)'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        plane_next  = plane_reg;
        ontime_next = ontime_reg;
        tick_info.row_address = 4'(row_reg);
        tick_info.bit_sel     = plane_reg;
        tick_info.strobe      = 1'b0;
        tick_info.latch       = 1'b0;
        tick_info.disp        = disp;
        if (tick_acc)
        begin
            if (disp)
            begin
                ontime_next = ontime_reg - TIME_BITS'(1);
            end
            unique case (phase_reg)
                lmbs_pkg::PH_SHIFT:
                begin
                    tick_info.strobe = 1'b1;
                    if (col_inc >= (COL_W + 1)'(cols_reg))
                    begin
                        col_next   = '0;
                        phase_next = lmbs_pkg::PH_LATCH;
                    end
                    else
                    begin
                        col_next = col_inc[COL_W-1:0];
                    end
                end
                lmbs_pkg::PH_LATCH:
                begin
                    if (!disp)
                    begin
                        tick_info.latch = 1'b1;
                        ontime_next     = time_tbl_reg[plane_reg];
                        if (plane_inc >= (PL_W + 1)'(depth_reg))
                        begin
                            plane_next = '0;
                            phase_next = lmbs_pkg::PH_ROWEND;
                        end
                        else
                        begin
                            plane_next = plane_inc[PL_W-1:0];
                            phase_next = lmbs_pkg::PH_SHIFT;
                        end
                    end
                end
                lmbs_pkg::PH_ROWEND:
                begin
                    if (!disp)
                    begin
                        if (row_inc >= (ROW_W + 1)'(rows_reg))
                        begin
                            row_next = '0;
                        end
                        else
                        begin
                            row_next = row_inc[ROW_W-1:0];
                        end
                        phase_next = lmbs_pkg::PH_SHIFT;
                    end
                end
                default:
                    phase_next = lmbs_pkg::PH_SHIFT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lmbs_pkg::PH_SHIFT;
            row_reg    <= '0;
            col_reg    <= '0;
            plane_reg  <= '0;
            ontime_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            plane_reg  <= plane_next;
            ontime_reg <= ontime_next;
        end
    end

    // Pick the plane bits; colors stay dark when nothing shifts
    always_comb
    begin
        color_bits = '0;
        if (s1_info_reg.strobe)
        begin
            color_bits[0] = up_reg[{2'b10, s1_info_reg.bit_sel}];
            color_bits[1] = up_reg[{2'b01, s1_info_reg.bit_sel}];
            color_bits[2] = up_reg[{2'b00, s1_info_reg.bit_sel}];
            color_bits[3] = lo_reg[{2'b10, s1_info_reg.bit_sel}];
            color_bits[4] = lo_reg[{2'b01, s1_info_reg.bit_sel}];
            color_bits[5] = lo_reg[{2'b00, s1_info_reg.bit_sel}];
        end
        out_data_next = {3'b000, s1_info_reg.disp, s1_info_reg.latch,
                         s1_info_reg.strobe, color_bits, s1_info_reg.row_address};
    end

    assign s1_valid_next  = tick_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_go ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Move the read stage and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s1_info_reg <= tick_info;
        end
        if (s1_go)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A tick in the shift phase always shifts a column
    `LMBS_ASSERT_NEXT(a_shift_strobes, tick_acc && (phase_reg == lmbs_pkg::PH_SHIFT), s1_valid_reg && s1_info_reg.strobe)
    // Latch only with the display dark and no shifting
    `LMBS_ASSERT_SAME(a_latch_dark, m_tvalid && m_tdata[11], !m_tdata[12] && !m_tdata[10])
    // Color pins low outside shifting
    `LMBS_ASSERT_SAME(a_dark_colors, m_tvalid && !m_tdata[10], m_tdata[9:4] == 6'd0)

endmodule

// ----- tb/tb_led_matrix_bitplane_scanner.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for led_matrix_bitplane_scanner: drives the command stream
// and the register port, predicts every pin level set and checks it on the output.
// Depends on lmbs_pkg and the scanner RTL only.

module tb_led_matrix_bitplane_scanner;
    import lmbs_pkg::*;

    localparam logic [1:0]           CMD_UNKNOWN     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE       = 2'd3;
    localparam int                   IDLE_LIMIT      = 3000;
    localparam int                   HOLD_CYCLES     = 300;
    localparam int                   DRAIN_CYCLES    = 8;
    localparam int                   PHASES          = 9;
    localparam int                   ITEMS_PER_PHASE = 40;
    localparam int                   STORE_ENTRIES   = 2 * MAX_ROW_PAIRS_DEF * MAX_COLUMNS_DEF;
    localparam int                   FIELDS          = 11;

    // Shadow of the scanner: registers, frame store, on-time table and scan counters
    class pin_level_scoreboard;
        logic [4:0]  row_pairs_reg;
        logic [7:0]  columns_reg;
        logic [3:0]  depth_reg;
        logic [23:0] frame_mem [STORE_ENTRIES];
        logic [15:0] on_time_tab [PLANE_COUNT];
        int          row_cnt;
        int          plane_cnt;
        int          col_cnt;
        int          on_cnt;
        phase_t      scan_phase;
        logic [15:0] pin_levels_q [$];
        string       field_name [FIELDS];
        int          field_lsb [FIELDS];
        int          field_width [FIELDS];
        int          errors;
        int          ticks;
        int          latches;
        int          lit_ticks;
        int          writes;

        function new();
            row_pairs_reg = 5'(ROW_PAIRS_RST);
            columns_reg   = 8'(COLUMNS_RST);
            depth_reg     = 4'(DEPTH_RST);
            foreach (on_time_tab[i])
                on_time_tab[i] = '0;
            row_cnt    = 0;
            plane_cnt  = 0;
            col_cnt    = 0;
            on_cnt     = 0;
            scan_phase = PH_SHIFT;
            errors     = 0;
            ticks      = 0;
            latches    = 0;
            lit_ticks  = 0;
            writes     = 0;
            field_name  = '{"row_address", "upper_red", "upper_green", "upper_blue",
                            "lower_red", "lower_green", "lower_blue", "shift_strobe",
                            "latch_pulse", "display_on", "pad"};
            field_lsb   = '{0, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13};
            field_width = '{4, 1, 1, 1, 1, 1, 1, 1, 1, 1, 3};
        endfunction

        // Saturate the registers into their legal ranges; zero acts as one
        function int pairs();
            return (row_pairs_reg == 0) ? 1 :
                   (row_pairs_reg > MAX_ROW_PAIRS_DEF) ? MAX_ROW_PAIRS_DEF : int'(row_pairs_reg);
        endfunction

        function int cols();
            return (columns_reg == 0) ? 1 :
                   (columns_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(columns_reg);
        endfunction

        function int planes();
            return (depth_reg == 0) ? 1 :
                   (depth_reg > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : int'(depth_reg);
        endfunction

        function int pending();
            return pin_levels_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ROW_PAIRS: row_pairs_reg = val[4:0];
                REG_COLUMNS:   columns_reg   = val;
                REG_DEPTH:     depth_reg     = val[3:0];
                default:       ;
            endcase
        endfunction

        // Apply one accepted command and queue the pin levels a tick produces
        function void accept_command(logic [1:0] cmd, logic [IN_DATA_W-1:0] data);
            logic [23:0] up;
            logic [23:0] lo;
            logic [15:0] pins;
            logic        disp;
            int          b;
            case (cmd)
                CMD_PIXEL:
                begin
                    frame_mem[{data[11:7], data[6:0]}] = {data[19:12], data[27:20], data[35:28]};
                    writes++;
                end
                CMD_TIME:
                begin
                    on_time_tab[data[38:36]] = data[54:39];
                    writes++;
                end
                CMD_TICK:
                begin
                    pins       = '0;
                    pins[3:0]  = 4'(row_cnt);
                    disp       = (on_cnt != 0);
                    pins[12]   = disp;
                    if (disp)
                        on_cnt--;
                    case (scan_phase)
                        PH_SHIFT:
                        begin
                            up = frame_mem[row_cnt * MAX_COLUMNS_DEF + col_cnt];
                            lo = frame_mem[(row_cnt + pairs()) * MAX_COLUMNS_DEF + col_cnt];
                            b  = plane_cnt;
                            pins[4]  = up[16 + b];
                            pins[5]  = up[8 + b];
                            pins[6]  = up[b];
                            pins[7]  = lo[16 + b];
                            pins[8]  = lo[8 + b];
                            pins[9]  = lo[b];
                            pins[10] = 1'b1;
                            col_cnt++;
                            if (col_cnt >= cols())
                            begin
                                col_cnt    = 0;
                                scan_phase = PH_LATCH;
                            end
                        end
                        PH_LATCH:
                        begin
                            // latch only once the previous plane has burned its on-time
                            if (!disp)
                            begin
                                pins[11] = 1'b1;
                                on_cnt   = int'(on_time_tab[plane_cnt]);
                                latches++;
                                plane_cnt++;
                                if (plane_cnt >= planes())
                                begin
                                    plane_cnt  = 0;
                                    scan_phase = PH_ROWEND;
                                end
                                else
                                begin
                                    scan_phase = PH_SHIFT;
                                end
                            end
                        end
                        default:
                        begin
                            if (!disp)
                            begin
                                row_cnt++;
                                if (row_cnt >= pairs())
                                    row_cnt = 0;
                                scan_phase = PH_SHIFT;
                            end
                        end
                    endcase
                    ticks++;
                    if (disp)
                        lit_ticks++;
                    pin_levels_q.push_back(pins);
                end
                default: ;
            endcase
        endfunction

        // Compare one output transaction against the oldest prediction
        function void check_pins(logic [OUT_DATA_W-1:0] actual);
            logic [15:0] expected;
            logic [15:0] e;
            logic [15:0] a;
            logic [15:0] mask;
            if (pin_levels_q.size() == 0)
            begin
                $error("pin levels %h arrived with no tick outstanding", actual);
                errors++;
                return;
            end
            expected = pin_levels_q.pop_front();
            for (int i = 0; i < FIELDS; i++)
            begin
                mask = (16'd1 << field_width[i]) - 16'd1;
                e    = (expected >> field_lsb[i]) & mask;
                a    = (actual >> field_lsb[i]) & mask;
                if (a !== e)
                begin
                    $error("%s: expected %0d, actual %0d", field_name[i], e, a);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    pin_level_scoreboard sb;
    bit pixel_written [STORE_ENTRIES];
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int idle_cycles = 0;

    led_matrix_bitplane_scanner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Observe both streams and watch for a stalled run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.accept_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_pins(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $error("no transaction for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_fields(logic [6:0] col, logic [4:0] row,
                                                         logic [7:0] red, logic [7:0] green,
                                                         logic [7:0] blue, logic [2:0] plane,
                                                         logic [15:0] on_time);
        return {1'b0, on_time, plane, blue, green, red, row, col};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_bits();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return {1'b0, r[54:0]};
    endfunction

    // Offer one command transaction, with random gaps ahead of it
    task automatic send_item(input logic [1:0] cmd, input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        if (cmd == CMD_PIXEL)
            pixel_written[{data[11:7], data[6:0]}] = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_on_time(input logic [2:0] plane, input logic [15:0] value);
        send_item(CMD_TIME, pack_fields(7'($urandom), 5'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom), plane, value));
    endtask

    // Drop valid and hold until every tick has come back and the block is quiet
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        // let the monitor log a transaction accepted at the edge just passed
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Write the three scan registers back to back, optionally the unused index too
    task automatic program_scan(input logic [7:0] rows_v, input logic [7:0] cols_v,
                                input logic [7:0] depth_v, input bit with_spare);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int                    n;
        idx  = '{REG_ROW_PAIRS, REG_COLUMNS, REG_DEPTH, REG_SPARE};
        vals = '{rows_v, cols_v, depth_v, 8'($urandom)};
        n    = with_spare ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Write every pixel the scan can reach under the current settings and state
    task automatic fill_store();
        int top_row;
        int last_col;
        top_row  = ((sb.row_cnt > sb.pairs() - 1) ? sb.row_cnt : sb.pairs() - 1) + sb.pairs();
        last_col = (sb.col_cnt > sb.cols() - 1) ? sb.col_cnt : sb.cols() - 1;
        for (int r = 0; r <= top_row; r++)
            for (int c = 0; c <= last_col; c++)
                if (!pixel_written[r * MAX_COLUMNS_DEF + c])
                    send_item(CMD_PIXEL, pack_fields(7'(c), 5'(r), 8'($urandom), 8'($urandom),
                                                     8'($urandom), 3'($urandom),
                                                     16'($urandom)));
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:
            begin
                tx_idle_pct = 14;
                rx_idle_pct = 76;
            end
            1:
            begin
                tx_idle_pct = 76;
                rx_idle_pct = 14;
            end
            default:
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    task automatic program_phase(input int p);
        case (p)
            0: program_scan(8'd0, 8'd255, 8'd15, 1'b0);
            1: program_scan(8'd1, 8'd0, 8'd0, 1'b0);
            2: program_scan(8'd31, 8'd6, 8'd8, 1'b0);
            3: program_scan(8'd16, 8'd1, 8'd1, 1'b0);
            4: program_scan(8'd3, 8'd5, 8'd4, 1'b0);
            6: program_scan(8'd7, 8'd12, 8'd2, 1'b0);
            8: program_scan(8'd16, 8'd8, 8'd8, 1'b1);
            default: program_scan(8'($urandom), 8'($urandom_range(0, 16)), 8'($urandom), 1'b1);
        endcase
    endtask

    task automatic run_directed();
        program_scan(8'd2, 8'd3, 8'd2, 1'b0);
        // Full-width on-times, replaced by short ones before any latch loads them
        send_on_time(3'd7, 16'hFFFF);
        send_on_time(3'd0, 16'hFFFF);
        send_on_time(3'd0, 16'd2);
        send_on_time(3'd7, 16'd1);
        // Corner pixels at extreme levels, one in the lower twin rows
        send_item(CMD_PIXEL, pack_fields(7'd127, 5'd31, 8'hFF, 8'hFF, 8'hFF, 3'd7, 16'hFFFF));
        send_item(CMD_PIXEL, pack_fields(7'd0, 5'd0, 8'h00, 8'h00, 8'h00, 3'd0, 16'd0));
        send_item(CMD_PIXEL, pack_fields(7'd1, 5'd2, 8'hFF, 8'h00, 8'hA5, 3'd0, 16'd0));
        send_item(CMD_UNKNOWN, {1'b0, {55{1'b1}}});
        fill_store();
        // Two planes per row pair; plane one keeps on-time zero and is never lit
        repeat (14)
            send_item(CMD_TICK, random_bits());
    endtask

    // One random command: mostly ticks, with pixel and on-time updates mixed in
    task automatic random_item();
        int pick;
        logic [2:0] plane;
        pick  = $urandom_range(0, 99);
        plane = 3'($urandom);
        if (pick < 70)
        begin
            send_item(CMD_TICK, random_bits());
        end
        else if (pick < 84)
        begin
            send_item(CMD_PIXEL, random_bits());
        end
        else if (pick < 94)
        begin
            if ($urandom_range(0, 9) == 0)
                send_on_time(plane, 16'($urandom_range(20, 90)));
            else
                send_on_time(plane, 16'($urandom_range(0, 5)));
        end
        else if (pick < 97)
        begin
            // wide value overwritten right away so the scan never stalls on it
            send_on_time(plane, 16'($urandom));
            send_on_time(plane, 16'($urandom_range(0, 3)));
        end
        else
        begin
            send_item(CMD_UNKNOWN, random_bits());
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            set_idle_mode(p / 3);
            program_phase(p);
            fill_store();
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // stall the output long enough to back up the input
                if (p == 2 && i == 20)
                    hold_req++;
                // let the pipeline run dry in the middle of a scan
                if (p == 4 && i == 20)
                    wait_idle();
                random_item();
            end
        end
        wait_idle();
        if (sb.pending() != 0)
        begin
            $error("%0d pin level sets never arrived", sb.pending());
            sb.errors++;
        end
        $display("Scan covered %0d ticks with %0d latches and %0d lit ticks",
                 sb.ticks, sb.latches, sb.lit_ticks);
        $display("Store and on-time writes: %0d across %0d register settings",
                 sb.writes, PHASES + 1);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
